FILE: hw/rtl/crfd_pkg.sv
// Package for the clipped rectangle fill core with damage tracking.
// Holds the transaction codes, field widths and shared types.
// No dependencies.
`timescale 1ns / 1ps

package crfd_pkg;

   localparam int MaxDim    = 4096;
   localparam int ColorBits = 16;

   localparam int CoordBits = 12;
   localparam int DimBits   = 13;
   localparam int AddrBits  = 24;
   localparam int ColorW    = 16;

   localparam logic [ColorW-1:0] ColorMask =
      (ColorBits >= ColorW) ? {ColorW{1'b1}} : ColorW'((32'd1 << ColorBits) - 32'd1);

   typedef logic [1:0]             mode_type;
   typedef logic [2:0]             status_type;
   typedef logic [CoordBits-1:0]   coord_type;
   typedef logic [DimBits-1:0]     dim_type;
   typedef logic [AddrBits-1:0]    addr_type;
   typedef logic [ColorW-1:0]      color_type;
   typedef logic signed [15:0]     sval_type;

   localparam mode_type ModeStart = 2'd0;
   localparam mode_type ModeTick  = 2'd1;
   localparam mode_type ModeClear = 2'd2;

   localparam status_type StatIdle    = 3'd0;
   localparam status_type StatAccept  = 3'd1;
   localparam status_type StatEmpty   = 3'd2;
   localparam status_type StatBusy    = 3'd3;
   localparam status_type StatBounds  = 3'd4;
   localparam status_type StatPixel   = 3'd5;
   localparam status_type StatCleared = 3'd6;

   localparam logic [2:0] RegFbWidth  = 3'd0;
   localparam logic [2:0] RegFbHeight = 3'd1;
   localparam logic [2:0] RegClipEn   = 3'd2;
   localparam logic [2:0] RegClipX    = 3'd3;
   localparam logic [2:0] RegClipY    = 3'd4;
   localparam logic [2:0] RegClipW    = 3'd5;
   localparam logic [2:0] RegClipH    = 3'd6;

   localparam dim_type FbResetDim = 13'd240;

endpackage

FILE: hw/rtl/clipped_rect_fill_with_damage_core.sv
// Top level of the clipped rectangle fill core with damage rectangle tracking.
// Depends on crfd_pkg for codes, widths and types.
//
//   channel | direction | tuser          | tdata / tlast
//   req     | in        | mode           | rect_x, rect_y, rect_w, rect_h, fill_color
//   rsp     | out       | status         | pixel write, busy, damage rect; tlast last_pixel
//   csr     | in        | -              | index and value of one register write
//
// A transaction accepted into the input register is computed combinationally and lands in the result
// register once that register is empty or being read, so results are presented in order of acceptance,
// at one per cycle while rsp is not stalled.
// Reset is synchronous and restores the register defaults and an idle engine.
// A stalled result register holds the input register, which then stalls req.
`timescale 1ns / 1ps

module clipped_rect_fill_with_damage_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // rect_x[12:0], rect_y[25:13], rect_w[38:26], rect_h[51:39], fill_color[67:52]
   input  logic [71:0]               req_tdata,
   // mode[1:0]
   input  crfd_pkg::mode_type        req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // write_addr[23:0], write_color[39:24], busy_res[40], damage_valid[41],
   // damage_x[53:42], damage_y[65:54], damage_w[78:66], damage_h[91:79]
   output logic [95:0]               rsp_tdata,
   // status[2:0]
   output crfd_pkg::status_type      rsp_tuser,
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [12:0]               csr_wdata
);

   import crfd_pkg::*;

   dim_type    fb_width_ff, fb_height_ff, clip_w_ff, clip_h_ff;
   coord_type  clip_x_ff, clip_y_ff;
   logic       clip_en_ff;

   logic       in_v_ff, out_v_ff, adv;
   logic [71:0] in_data_ff;
   mode_type   in_mode_ff;

   logic [95:0] out_data_ff, out_data_in;
   status_type  out_stat_ff, stat;
   logic        out_last_ff, wlast;
   addr_type    waddr;
   color_type   wcol;

   logic       busy_ff, busy_in;
   coord_type  col_ff, col_in, first_ff, first_in, lastc_ff, lastc_in;
   coord_type  row_ff, row_in, frow_ff, frow_in;
   addr_type   caddr_ff, caddr_in;
   color_type  hcol_ff, hcol_in;
   logic       dflag_ff, dflag_in;
   coord_type  dl_ff, dl_in, dt_ff, dt_in;
   dim_type    dw_ff, dw_in, dh_ff, dh_in;

   sval_type   x, y, w, h, cx, cy, cr, cb, r0, b0, x1, y1, r1, b1, w1, h1;
   sval_type   fw_s, fh_s, ml, mt, mr, mb, odr, odb;
   dim_type    fw, fh;
   logic       empty_raw, clip_miss, clip_empty, oob;
   logic [24:0] prod;
   coord_type  span;

   assign adv        = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || adv;

   assign x  = sval_type'($signed(in_data_ff[12:0]));
   assign y  = sval_type'($signed(in_data_ff[25:13]));
   assign w  = sval_type'($signed(in_data_ff[38:26]));
   assign h  = sval_type'($signed(in_data_ff[51:39]));
   assign cx = $signed({4'b0, clip_x_ff});
   assign cy = $signed({4'b0, clip_y_ff});
   assign cr = cx + $signed({3'b0, clip_w_ff});
   assign cb = cy + $signed({3'b0, clip_h_ff});
   assign r0 = x + w;
   assign b0 = y + h;
   assign x1 = (clip_en_ff && x < cx) ? cx : x;
   assign y1 = (clip_en_ff && y < cy) ? cy : y;
   assign r1 = (clip_en_ff && r0 > cr) ? cr : r0;
   assign b1 = (clip_en_ff && b0 > cb) ? cb : b0;
   assign w1 = r1 - x1;
   assign h1 = b1 - y1;

   assign fw   = (fb_width_ff > dim_type'(MaxDim)) ? dim_type'(MaxDim) : fb_width_ff;
   assign fh   = (fb_height_ff > dim_type'(MaxDim)) ? dim_type'(MaxDim) : fb_height_ff;
   assign fw_s = $signed({3'b0, fw});
   assign fh_s = $signed({3'b0, fh});

   assign empty_raw  = (w <= 16'sd0) || (h <= 16'sd0);
   assign clip_miss  = clip_en_ff && (x >= cr || y >= cb || r0 <= cx || b0 <= cy);
   assign clip_empty = (w1 <= 16'sd0) || (h1 <= 16'sd0);
   assign oob        = (x1 < 16'sd0) || (y1 < 16'sd0) || (r1 > fw_s) || (b1 > fh_s);
   assign prod       = {13'b0, y1[11:0]} * {12'b0, fw};

   assign odr = $signed({4'b0, dl_ff}) + $signed({3'b0, dw_ff});
   assign odb = $signed({4'b0, dt_ff}) + $signed({3'b0, dh_ff});
   assign ml  = (x1 < $signed({4'b0, dl_ff})) ? x1 : $signed({4'b0, dl_ff});
   assign mt  = (y1 < $signed({4'b0, dt_ff})) ? y1 : $signed({4'b0, dt_ff});
   assign mr  = (r1 > odr) ? r1 : odr;
   assign mb  = (b1 > odb) ? b1 : odb;

   assign span = lastc_ff - first_ff;

   always_comb begin
      stat     = StatIdle;
      waddr    = '0;
      wcol     = '0;
      wlast    = 1'b0;
      busy_in  = busy_ff;
      col_in   = col_ff;
      first_in = first_ff;
      lastc_in = lastc_ff;
      row_in   = row_ff;
      frow_in  = frow_ff;
      caddr_in = caddr_ff;
      hcol_in  = hcol_ff;
      dflag_in = dflag_ff;
      dl_in    = dl_ff;
      dt_in    = dt_ff;
      dw_in    = dw_ff;
      dh_in    = dh_ff;
      unique case (in_mode_ff)
         ModeStart: begin
            if (busy_ff) begin
               stat = StatBusy;
            end else if (empty_raw || clip_miss || clip_empty) begin
               stat = StatEmpty;
            end else if (oob) begin
               stat = StatBounds;
            end else begin
               stat     = StatAccept;
               busy_in  = 1'b1;
               col_in   = x1[11:0];
               first_in = x1[11:0];
               lastc_in = coord_type'(r1 - 16'sd1);
               row_in   = y1[11:0];
               frow_in  = coord_type'(b1 - 16'sd1);
               caddr_in = addr_type'(prod + {13'b0, x1[11:0]});
               hcol_in  = in_data_ff[67:52] & ColorMask;
               dflag_in = 1'b1;
               if (!dflag_ff) begin
                  dl_in = x1[11:0];
                  dt_in = y1[11:0];
                  dw_in = w1[12:0];
                  dh_in = h1[12:0];
               end else begin
                  dl_in = ml[11:0];
                  dt_in = mt[11:0];
                  dw_in = dim_type'(mr - ml);
                  dh_in = dim_type'(mb - mt);
               end
            end
         end
         ModeTick: begin
            if (busy_ff) begin
               stat  = StatPixel;
               waddr = caddr_ff;
               wcol  = hcol_ff;
               if (col_ff == lastc_ff) begin
                  if (row_ff == frow_ff) begin
                     wlast   = 1'b1;
                     busy_in = 1'b0;
                  end else begin
                     caddr_in = caddr_ff + addr_type'(fw) - addr_type'(span);
                     row_in   = row_ff + 12'd1;
                     col_in   = first_ff;
                  end
               end else begin
                  col_in   = col_ff + 12'd1;
                  caddr_in = caddr_ff + 24'd1;
               end
            end
         end
         ModeClear: begin
            stat     = StatCleared;
            dflag_in = 1'b0;
            dl_in    = '0;
            dt_in    = '0;
            dw_in    = '0;
            dh_in    = '0;
         end
         default: begin
            stat = StatIdle;
         end
      endcase
      out_data_in = {4'b0, dh_in, dw_in, dt_in, dl_in, dflag_in, busy_in, wcol, waddr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= FbResetDim;
         fb_height_ff <= FbResetDim;
         clip_en_ff   <= 1'b0;
         clip_x_ff    <= '0;
         clip_y_ff    <= '0;
         clip_w_ff    <= '0;
         clip_h_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            RegFbWidth:  fb_width_ff  <= csr_wdata;
            RegFbHeight: fb_height_ff <= csr_wdata;
            RegClipEn:   clip_en_ff   <= csr_wdata[0];
            RegClipX:    clip_x_ff    <= csr_wdata[11:0];
            RegClipY:    clip_y_ff    <= csr_wdata[11:0];
            RegClipW:    clip_w_ff    <= csr_wdata;
            RegClipH:    clip_h_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         busy_ff  <= 1'b0;
         col_ff   <= '0;
         first_ff <= '0;
         lastc_ff <= '0;
         row_ff   <= '0;
         frow_ff  <= '0;
         caddr_ff <= '0;
         hcol_ff  <= '0;
         dflag_ff <= 1'b0;
         dl_ff    <= '0;
         dt_ff    <= '0;
         dw_ff    <= '0;
         dh_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_v_ff <= req_tvalid;
         end
         if (adv) begin
            out_v_ff <= 1'b1;
            busy_ff  <= busy_in;
            col_ff   <= col_in;
            first_ff <= first_in;
            lastc_ff <= lastc_in;
            row_ff   <= row_in;
            frow_ff  <= frow_in;
            caddr_ff <= caddr_in;
            hcol_ff  <= hcol_in;
            dflag_ff <= dflag_in;
            dl_ff    <= dl_in;
            dt_ff    <= dt_in;
            dw_ff    <= dw_in;
            dh_ff    <= dh_in;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_mode_ff <= req_tuser;
      end
      if (adv) begin
         out_data_ff <= out_data_in;
         out_stat_ff <= stat;
         out_last_ff <= wlast;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
